// ----- hw/rtl/ipsc_pkg.sv -----
// Shared types, constants and control/status structures for the IR pulse/space capture block.
// Used by ipsc_ctrl, ipsc_datapath and the top level; no dependencies.
`default_nettype none
package ipsc_pkg;

   localparam int COUNT_WIDTH_DEF = 32;

   localparam logic [7:0]  SPACE_RATIO_RST    = 8'd40;
   localparam logic [15:0] MAX_ENTRIES_RST    = 16'd256;
   localparam logic [15:0] MAX_TIME_UNITS_RST = 16'd129;
   localparam logic        WAIT_FOR_HIGH_RST  = 1'b1;
   localparam logic [27:0] TICK_HZ_RST        = 28'd84000000;
   localparam logic [7:0]  TICKS_PER_US_RST   = 8'd84;

   localparam int PADDR_WIDTH = 5;

   typedef enum logic [2:0] {
      REG_SPACE_RATIO    = 3'd0,
      REG_MAX_ENTRIES    = 3'd1,
      REG_MAX_TIME_UNITS = 3'd2,
      REG_WAIT_FOR_HIGH  = 3'd3,
      REG_TICK_HZ        = 3'd4,
      REG_TICKS_PER_US   = 3'd5
   } reg_idx_type;

   typedef enum logic [1:0] {
      KIND_BURST = 2'd0,
      KIND_SPACE = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      DIV_AVG      = 3'd0,
      DIV_BURST_US = 3'd1,
      DIV_SPACE_US = 3'd2,
      DIV_PERIOD   = 3'd3,
      DIV_DUTY     = 3'd4,
      DIV_HZ       = 3'd5
   } div_sel_type;

   typedef struct packed {
      logic [7:0]  space_ratio;
      logic [15:0] max_entries;
      logic [15:0] max_time_units;
      logic        wait_for_high;
      logic [27:0] tick_hz;
      logic [7:0]  ticks_per_us;
   } cfg_type;

   typedef struct packed {
      logic        clear;
      logic        count;
      logic        run_one;
      logic        high_to_low;
      logic        low_join;
      logic        commit_space;
      logic        entry_inc;
      logic        div_start;
      div_sel_type div_sel;
      logic        avg_from_div;
      logic        avg_from_burst;
      logic        mul_load;
      logic        latch_period;
      logic        latch_duty;
      logic        latch_hz;
      logic        out_load;
      kind_type    out_kind;
      logic        out_summary_ok;
   } cmd_type;

   typedef struct packed {
      logic timeout;
      logic is_space;
      logic at_limit;
      logic hp_zero;
      logic total_zero;
      logic halves_zero;
      logic quo_zero;
      logic div_busy;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ----- hw/rtl/ipsc_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by all divisions of the block.
// Stand-alone; the divisor must be nonzero when started.
`default_nettype none
module ipsc_div #(
   parameter int DW = 39,
   parameter int VW = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output logic               busy,
   output logic [DW-1:0]      quotient
);

   localparam int CNT_W = $clog2(DW + 1);

   logic [VW-1:0]    rem_ff;
   logic [DW-1:0]    quo_ff;
   logic [VW-1:0]    dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic [VW:0]      trial;
   logic [VW:0]      diff;
   logic             ge;

   assign trial = {rem_ff, quo_ff[DW-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(DW);
         rem_ff  <= '0;
         quo_ff  <= dividend;
         dvs_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= ge ? diff[VW-1:0] : trial[VW-1:0];
         quo_ff  <= {quo_ff[DW-2:0], ge};
         cnt_ff  <= cnt_ff - 1'b1;
         busy_ff <= (cnt_ff != CNT_W'(1));
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/ipsc_datapath.sv -----
// Counters, running totals, threshold product, divider operands and the result register.
// Depends on ipsc_pkg and ipsc_div; driven by commands from ipsc_ctrl.
`default_nettype none
module ipsc_datapath
   import ipsc_pkg::*;
#(
   parameter int CW = COUNT_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire cmd_type     cmd,
   output status_type       status,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [31:0]      rsp_duration_us,
   output logic [15:0]      rsp_entry_index,
   output logic [6:0]       rsp_duty_percent,
   output logic [27:0]      rsp_carrier_hz,
   output logic             rsp_summary_valid,
   output logic             rsp_last
);

   localparam int DW = (CW + 7 > 28) ? CW + 7 : 28;

   logic [CW-1:0]   run_ff, bh_ff, bl_ff, hp_ff, th_ff, tl_ff, thp_ff, avg_ff, period_ff;
   logic [15:0]     span_ff, entry_ff;
   logic [CW+7:0]   prod_ff;
   logic [6:0]      duty_ff;
   logic [27:0]     hz_ff;
   logic            rsp_valid_ff;
   logic [1:0]      kind_ff;
   logic [31:0]     dur_ff;
   logic [15:0]     idx_ff;
   logic [6:0]      rduty_ff;
   logic [27:0]     rhz_ff;
   logic            rsv_ff, rlast_ff;

   logic [CW-1:0]   run_inc, burst, total, halves;
   logic [15:0]     span_inc, limit;
   logic [7:0]      tpu_eff;
   logic [CW+6:0]   th_x100;
   logic [DW-1:0]   dividend;
   logic [CW-1:0]   divisor;
   logic [DW-1:0]   quotient;
   logic [DW+31:0]  quo_ext;
   logic            div_busy;

   assign run_inc  = run_ff + 1'b1;
   assign span_inc = span_ff + 1'b1;
   assign burst    = bh_ff + bl_ff;
   assign total    = th_ff + tl_ff;
   assign halves   = thp_ff >> 1;
   assign limit    = cfg.max_entries - 16'd1;
   assign tpu_eff  = (cfg.ticks_per_us == 8'd0) ? 8'd1 : cfg.ticks_per_us;
   assign th_x100  = (CW + 7)'(th_ff) * (CW + 7)'(100);
   assign quo_ext  = {32'd0, quotient};

   always_comb begin
      unique case (cmd.div_sel)
         DIV_AVG: begin
            dividend = DW'(burst);
            divisor  = hp_ff;
         end
         DIV_BURST_US: begin
            dividend = DW'(burst);
            divisor  = CW'(tpu_eff);
         end
         DIV_SPACE_US: begin
            dividend = DW'(run_ff);
            divisor  = CW'(tpu_eff);
         end
         DIV_PERIOD: begin
            dividend = DW'(total);
            divisor  = halves;
         end
         DIV_DUTY: begin
            dividend = DW'(th_x100);
            divisor  = total;
         end
         DIV_HZ: begin
            dividend = DW'(cfg.tick_hz);
            divisor  = period_ff;
         end
         default: begin
            dividend = '0;
            divisor  = CW'(1);
         end
      endcase
   end

   ipsc_div #(.DW(DW), .VW(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         run_ff   <= '0;
         span_ff  <= '0;
         bh_ff    <= '0;
         bl_ff    <= '0;
         hp_ff    <= '0;
         th_ff    <= '0;
         tl_ff    <= '0;
         thp_ff   <= '0;
         entry_ff <= '0;
      end else begin
         if (cmd.count) begin
            run_ff <= run_inc;
            if (run_inc[15:0] == 16'd0) begin
               span_ff <= span_inc;
            end
         end
         if (cmd.run_one) begin
            run_ff <= CW'(1);
         end
         if (cmd.high_to_low) begin
            hp_ff  <= hp_ff + 1'b1;
            bh_ff  <= bh_ff + run_ff;
            run_ff <= CW'(1);
         end
         if (cmd.low_join) begin
            hp_ff  <= hp_ff + 1'b1;
            bl_ff  <= bl_ff + run_ff;
            run_ff <= CW'(1);
         end
         if (cmd.commit_space) begin
            th_ff  <= th_ff + bh_ff;
            tl_ff  <= tl_ff + bl_ff;
            thp_ff <= thp_ff + hp_ff;
            bh_ff  <= '0;
            bl_ff  <= '0;
            hp_ff  <= '0;
            run_ff <= CW'(1);
         end
         if (cmd.entry_inc) begin
            entry_ff <= entry_ff + 1'b1;
         end
      end
      if (cmd.avg_from_div) begin
         avg_ff <= quotient[CW-1:0];
      end
      if (cmd.avg_from_burst) begin
         avg_ff <= burst;
      end
      if (cmd.mul_load) begin
         prod_ff <= (CW + 8)'(avg_ff) * (CW + 8)'(cfg.space_ratio);
      end
      if (cmd.latch_period) begin
         period_ff <= quotient[CW-1:0];
      end
      if (cmd.latch_duty) begin
         duty_ff <= quotient[6:0];
      end
      if (cmd.latch_hz) begin
         hz_ff <= quotient[27:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         kind_ff  <= cmd.out_kind;
         idx_ff   <= entry_ff;
         rlast_ff <= (cmd.out_kind != KIND_BURST);
         if (cmd.out_kind == KIND_END) begin
            dur_ff   <= '0;
            rduty_ff <= cmd.out_summary_ok ? duty_ff : 7'd0;
            rhz_ff   <= cmd.out_summary_ok ? hz_ff : 28'd0;
            rsv_ff   <= cmd.out_summary_ok;
         end else begin
            dur_ff   <= quo_ext[31:0];
            rduty_ff <= '0;
            rhz_ff   <= '0;
            rsv_ff   <= 1'b0;
         end
      end
   end

   always_comb begin
      status.timeout     = (run_inc[15:0] == 16'd0) && (span_inc >= cfg.max_time_units);
      status.is_space    = {8'd0, run_ff} > prod_ff;
      status.at_limit    = (entry_ff == limit);
      status.hp_zero     = (hp_ff == '0);
      status.total_zero  = (total == '0);
      status.halves_zero = (halves == '0);
      status.quo_zero    = (quotient == '0);
      status.div_busy    = div_busy;
      status.out_free    = !rsp_valid_ff;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_duration_us   = dur_ff;
   assign rsp_entry_index   = idx_ff;
   assign rsp_duty_percent  = rduty_ff;
   assign rsp_carrier_hz    = rhz_ff;
   assign rsp_summary_valid = rsv_ff;
   assign rsp_last          = rlast_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/ipsc_ctrl.sv -----
// Controller state machine: capture phase, input transfers and sequencing of divides and results.
// Depends on ipsc_pkg; commands ipsc_datapath through cmd_type and reads status_type.
`default_nettype none
module ipsc_ctrl
   import ipsc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_cmd,
   input  wire logic       req_pin_level,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_HIGH, PH_LOW} phase_type;
   typedef enum logic [3:0] {
      ST_IDLE, ST_AVG, ST_MUL, ST_CMP, ST_BDIV, ST_BOUT, ST_BCHK, ST_SDIV, ST_SOUT,
      ST_FIN, ST_FPER, ST_FDUTY, ST_FHZ, ST_FOUT
   } state_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      ok_ff, ok_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      phase_in = phase_ff;
      ok_in    = ok_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_cmd) begin
                  cmd.clear = 1'b1;
                  phase_in  = cfg.wait_for_high ? PH_WAIT : PH_HIGH;
               end else begin
                  unique case (phase_ff)
                     PH_IDLE: begin
                     end
                     PH_WAIT: begin
                        if (req_pin_level) begin
                           phase_in    = PH_HIGH;
                           cmd.run_one = 1'b1;
                        end
                     end
                     PH_HIGH: begin
                        if (req_pin_level) begin
                           cmd.count = 1'b1;
                           if (status.timeout) begin
                              state_in = ST_FIN;
                           end
                        end else begin
                           cmd.high_to_low = 1'b1;
                           phase_in        = PH_LOW;
                        end
                     end
                     PH_LOW: begin
                        if (!req_pin_level) begin
                           cmd.count = 1'b1;
                           if (status.timeout) begin
                              state_in = ST_FIN;
                           end
                        end else if (status.hp_zero) begin
                           cmd.avg_from_burst = 1'b1;
                           state_in           = ST_MUL;
                        end else begin
                           cmd.div_start = 1'b1;
                           cmd.div_sel   = DIV_AVG;
                           state_in      = ST_AVG;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_AVG: begin
            if (!status.div_busy) begin
               cmd.avg_from_div = 1'b1;
               state_in         = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_CMP;
         end
         ST_CMP: begin
            if (!status.is_space) begin
               cmd.low_join = 1'b1;
               phase_in     = PH_HIGH;
               state_in     = ST_IDLE;
            end else if (status.at_limit) begin
               state_in = ST_FIN;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_BURST_US;
               state_in      = ST_BDIV;
            end
         end
         ST_BDIV: begin
            if (!status.div_busy) begin
               state_in = ST_BOUT;
            end
         end
         ST_BOUT: begin
            if (status.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_kind  = KIND_BURST;
               cmd.entry_inc = 1'b1;
               state_in      = ST_BCHK;
            end
         end
         ST_BCHK: begin
            if (status.at_limit) begin
               state_in = ST_FIN;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SPACE_US;
               state_in      = ST_SDIV;
            end
         end
         ST_SDIV: begin
            if (!status.div_busy) begin
               state_in = ST_SOUT;
            end
         end
         ST_SOUT: begin
            if (status.out_free) begin
               cmd.out_load     = 1'b1;
               cmd.out_kind     = KIND_SPACE;
               cmd.entry_inc    = 1'b1;
               cmd.commit_space = 1'b1;
               phase_in         = PH_HIGH;
               state_in         = ST_IDLE;
            end
         end
         ST_FIN: begin
            if (status.total_zero || status.halves_zero) begin
               ok_in    = 1'b0;
               state_in = ST_FOUT;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_PERIOD;
               state_in      = ST_FPER;
            end
         end
         ST_FPER: begin
            if (!status.div_busy) begin
               cmd.latch_period = 1'b1;
               if (status.quo_zero) begin
                  ok_in    = 1'b0;
                  state_in = ST_FOUT;
               end else begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = DIV_DUTY;
                  state_in      = ST_FDUTY;
               end
            end
         end
         ST_FDUTY: begin
            if (!status.div_busy) begin
               cmd.latch_duty = 1'b1;
               cmd.div_start  = 1'b1;
               cmd.div_sel    = DIV_HZ;
               state_in       = ST_FHZ;
            end
         end
         ST_FHZ: begin
            if (!status.div_busy) begin
               cmd.latch_hz = 1'b1;
               ok_in        = 1'b1;
               state_in     = ST_FOUT;
            end
         end
         ST_FOUT: begin
            if (status.out_free) begin
               cmd.out_load       = 1'b1;
               cmd.out_kind       = KIND_END;
               cmd.out_summary_ok = ok_ff;
               phase_in           = PH_IDLE;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_IDLE;
         ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         ok_ff    <= ok_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/ir_pulse_space_capture.sv -----
// IR pulse/space capture top level: register port, controller and datapath.
// Depends on ipsc_pkg, ipsc_ctrl and ipsc_datapath.
// A tick inside a run only counts; a high sample ending a low run also runs the average
// divide, multiply and compare, a space both conversions on the one-bit-per-cycle divider,
// and capture end the period, duty and frequency divides; no tick is taken meanwhile.
// Results wait in an output register. Synchronous reset idles the block and loads defaults.
`default_nettype none
module ir_pulse_space_capture
   import ipsc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [PADDR_WIDTH-1:0] paddr,
   input  wire logic [31:0]            pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_cmd,
   input  wire logic                   req_pin_level,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [1:0]                  rsp_kind,
   output logic [31:0]                 rsp_duration_us,
   output logic [15:0]                 rsp_entry_index,
   output logic [6:0]                  rsp_duty_percent,
   output logic [27:0]                 rsp_carrier_hz,
   output logic                        rsp_summary_valid,
   output logic                        rsp_last
);

   cfg_type     cfg_ff;
   cmd_type     cmd;
   status_type  status;
   reg_idx_type reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = reg_idx_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.space_ratio    <= SPACE_RATIO_RST;
         cfg_ff.max_entries    <= MAX_ENTRIES_RST;
         cfg_ff.max_time_units <= MAX_TIME_UNITS_RST;
         cfg_ff.wait_for_high  <= WAIT_FOR_HIGH_RST;
         cfg_ff.tick_hz        <= TICK_HZ_RST;
         cfg_ff.ticks_per_us   <= TICKS_PER_US_RST;
      end else if (psel && penable && pwrite) begin
         case (reg_idx)
            REG_SPACE_RATIO:    cfg_ff.space_ratio    <= pwdata[7:0];
            REG_MAX_ENTRIES:    cfg_ff.max_entries    <= pwdata[15:0];
            REG_MAX_TIME_UNITS: cfg_ff.max_time_units <= pwdata[15:0];
            REG_WAIT_FOR_HIGH:  cfg_ff.wait_for_high  <= pwdata[0];
            REG_TICK_HZ:        cfg_ff.tick_hz        <= pwdata[27:0];
            REG_TICKS_PER_US:   cfg_ff.ticks_per_us   <= pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SPACE_RATIO:    prdata = 32'(cfg_ff.space_ratio);
         REG_MAX_ENTRIES:    prdata = 32'(cfg_ff.max_entries);
         REG_MAX_TIME_UNITS: prdata = 32'(cfg_ff.max_time_units);
         REG_WAIT_FOR_HIGH:  prdata = 32'(cfg_ff.wait_for_high);
         REG_TICK_HZ:        prdata = 32'(cfg_ff.tick_hz);
         REG_TICKS_PER_US:   prdata = 32'(cfg_ff.ticks_per_us);
         default:            prdata = '0;
      endcase
   end

   ipsc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_pin_level (req_pin_level),
      .status        (status),
      .cmd           (cmd)
   );

   ipsc_datapath #(.CW(COUNT_WIDTH)) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_duration_us   (rsp_duration_us),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_duty_percent  (rsp_duty_percent),
      .rsp_carrier_hz    (rsp_carrier_hz),
      .rsp_summary_valid (rsp_summary_valid),
      .rsp_last          (rsp_last)
   );

endmodule
`default_nettype wire

// ----- bench/ir_pulse_space_capture_tb.sv -----
// Self-checking testbench for the IR pulse/space capture block: directed and random captures,
// predicted in the bench and compared transfer by transfer. Depends on ipsc_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module ir_pulse_space_capture_tb;
   import ipsc_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 300;

   typedef enum logic [1:0] {CAP_IDLE, CAP_WAIT, CAP_HIGH, CAP_LOW} cap_phase_type;

   typedef struct {
      logic cmd;
      logic pin;
   } tick_item_type;

   typedef struct {
      kind_type    kind;
      logic [31:0] duration_us;
      logic [15:0] entry_index;
      logic [6:0]  duty_percent;
      logic [27:0] carrier_hz;
      logic        summary_valid;
      logic        last;
   } entry_type;

   logic clock, reset;
   logic psel, penable, pwrite;
   logic [PADDR_WIDTH-1:0] paddr;
   logic [31:0] pwdata, prdata;
   logic pready;
   logic req_valid, req_ready, req_cmd, req_pin_level;
   logic rsp_valid, rsp_ready;
   logic [1:0] rsp_kind;
   logic [31:0] rsp_duration_us;
   logic [15:0] rsp_entry_index;
   logic [6:0] rsp_duty_percent;
   logic [27:0] rsp_carrier_hz;
   logic rsp_summary_valid, rsp_last;

   ir_pulse_space_capture dut (.*);

   tick_item_type pending_ticks[$];
   entry_type     expected_entries[$];
   int send_idle_pct, recv_idle_pct;
   int errors, ticks_accepted, entries_checked, captures_run;
   int quiet_cycles;

   // Predicted configuration and capture state.
   logic [7:0]  m_ratio;
   logic [15:0] m_max_entries, m_max_units;
   logic        m_wait;
   logic [27:0] m_tick_hz;
   logic [7:0]  m_tpu;
   cap_phase_type m_phase;
   logic [31:0] m_run, m_burst_high, m_burst_low, m_half_periods;
   logic [31:0] m_total_high, m_total_low, m_total_halves;
   logic [15:0] m_spans, m_entries;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch on %s at result %0d: got %0d, expected %0d",
               what, entries_checked, got, want);
      errors++;
   endtask

   function automatic logic [31:0] ticks_to_us(input logic [31:0] ticks);
      logic [31:0] d;
      d = (m_tpu == 0) ? 32'd1 : {24'd0, m_tpu};
      return ticks / d;
   endfunction

   function automatic entry_type make_entry(input kind_type k, input logic [31:0] dur);
      entry_type e;
      e.kind = k;
      e.duration_us = dur;
      e.entry_index = m_entries;
      e.duty_percent = '0;
      e.carrier_hz = '0;
      e.summary_valid = 1'b0;
      e.last = 1'b0;
      return e;
   endfunction

   function automatic entry_type end_of_capture();
      entry_type e;
      logic [31:0] total, halves, period;
      logic [63:0] duty;
      e = make_entry(KIND_END, '0);
      total = m_total_high + m_total_low;
      halves = m_total_halves >> 1;
      period = (halves != 0) ? total / halves : 32'd0;
      if (total != 0 && halves != 0 && period != 0) begin
         duty = ({32'd0, m_total_high} * 64'd100) / {32'd0, total};
         e.duty_percent = duty[6:0];
         e.carrier_hz = 28'({4'd0, m_tick_hz} / period);
         e.summary_valid = 1'b1;
      end
      m_phase = CAP_IDLE;
      return e;
   endfunction

   function automatic logic run_times_out();
      m_run = m_run + 32'd1;
      if (m_run[15:0] == 16'd0) begin
         m_spans = m_spans + 16'd1;
         return m_spans >= m_max_units;
      end
      return 1'b0;
   endfunction

   task automatic predict_tick(input logic cmd, input logic pin);
      entry_type produced[$];
      logic [31:0] burst, avg;
      logic [63:0] threshold;
      logic [15:0] limit;
      limit = m_max_entries - 16'd1;
      if (!cmd) begin
         {m_run, m_burst_high, m_burst_low, m_half_periods} = '0;
         {m_total_high, m_total_low, m_total_halves, m_spans, m_entries} = '0;
         m_phase = m_wait ? CAP_WAIT : CAP_HIGH;
         return;
      end
      case (m_phase)
         CAP_WAIT: if (pin) begin
            m_phase = CAP_HIGH;
            m_run = 32'd1;
         end
         CAP_HIGH: begin
            if (pin) begin
               if (run_times_out()) produced.push_back(end_of_capture());
            end else begin
               m_half_periods = m_half_periods + 32'd1;
               m_burst_high = m_burst_high + m_run;
               m_run = 32'd1;
               m_phase = CAP_LOW;
            end
         end
         CAP_LOW: begin
            if (!pin) begin
               if (run_times_out()) produced.push_back(end_of_capture());
            end else begin
               burst = m_burst_high + m_burst_low;
               avg = (m_half_periods != 0) ? burst / m_half_periods : burst;
               threshold = {32'd0, avg} * {56'd0, m_ratio};
               m_phase = CAP_HIGH;
               if ({32'd0, m_run} > threshold) begin
                  if (m_entries == limit) begin
                     produced.push_back(end_of_capture());
                  end else begin
                     produced.push_back(make_entry(KIND_BURST, ticks_to_us(burst)));
                     m_entries = m_entries + 16'd1;
                     if (m_entries == limit) begin
                        produced.push_back(end_of_capture());
                     end else begin
                        produced.push_back(make_entry(KIND_SPACE, ticks_to_us(m_run)));
                        m_entries = m_entries + 16'd1;
                        m_total_high = m_total_high + m_burst_high;
                        m_total_low = m_total_low + m_burst_low;
                        m_total_halves = m_total_halves + m_half_periods;
                        {m_burst_high, m_burst_low, m_half_periods} = '0;
                     end
                  end
               end else begin
                  m_half_periods = m_half_periods + 32'd1;
                  m_burst_low = m_burst_low + m_run;
               end
               m_run = 32'd1;
            end
         end
         default: ;
      endcase
      if (produced.size() > 0) produced[produced.size()-1].last = 1'b1;
      foreach (produced[i]) expected_entries.push_back(produced[i]);
   endtask

   // Driver of the tick channel; predicts each transfer as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_tick(req_cmd, req_pin_level);
            ticks_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_cmd <= pending_ticks[0].cmd;
               req_pin_level <= pending_ticks[0].pin;
               pending_ticks.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor of the result channel, with the stall watchdog.
   always @(posedge clock) begin
      entry_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (expected_entries.size() == 0) begin
               report("unexpected result kind", 32'(rsp_kind), 32'd0);
            end else begin
               e = expected_entries.pop_front();
               if (rsp_kind != e.kind) report("kind", 32'(rsp_kind), 32'(e.kind));
               if (rsp_duration_us != e.duration_us)
                  report("duration_us", rsp_duration_us, e.duration_us);
               if (rsp_entry_index != e.entry_index)
                  report("entry_index", 32'(rsp_entry_index), 32'(e.entry_index));
               if (rsp_duty_percent != e.duty_percent)
                  report("duty_percent", 32'(rsp_duty_percent), 32'(e.duty_percent));
               if (rsp_carrier_hz != e.carrier_hz)
                  report("carrier_hz", 32'(rsp_carrier_hz), 32'(e.carrier_hz));
               if (rsp_summary_valid != e.summary_valid)
                  report("summary_valid", 32'(rsp_summary_valid), 32'(e.summary_valid));
               if (rsp_last != e.last) report("last", 32'(rsp_last), 32'(e.last));
            end
            entries_checked++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic write_reg(input reg_idx_type idx, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= PADDR_WIDTH'({idx, 2'b00});
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_SPACE_RATIO:    m_ratio = value[7:0];
         REG_MAX_ENTRIES:    m_max_entries = value[15:0];
         REG_MAX_TIME_UNITS: m_max_units = value[15:0];
         REG_WAIT_FOR_HIGH:  m_wait = value[0];
         REG_TICK_HZ:        m_tick_hz = value[27:0];
         REG_TICKS_PER_US:   m_tpu = value[7:0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [7:0] ratio, input logic [15:0] entries,
                            input logic [15:0] units, input logic wait_high,
                            input logic [27:0] hz, input logic [7:0] tpu);
      write_reg(REG_SPACE_RATIO, {24'd0, ratio});
      write_reg(REG_MAX_ENTRIES, {16'd0, entries});
      write_reg(REG_MAX_TIME_UNITS, {16'd0, units});
      write_reg(REG_WAIT_FOR_HIGH, {31'd0, wait_high});
      write_reg(REG_TICK_HZ, {4'd0, hz});
      write_reg(REG_TICKS_PER_US, {24'd0, tpu});
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_ticks.size() > 0 || req_valid || expected_entries.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic push_ticks(input logic cmd, input logic pin, input int count);
      tick_item_type t;
      t.cmd = cmd;
      t.pin = pin;
      repeat (count) pending_ticks.push_back(t);
   endtask

   task automatic random_capture();
      logic [7:0] ratio;
      logic [15:0] entries;
      logic [27:0] hz;
      logic [7:0] tpu;
      int bursts;
      case ($urandom_range(9))
         0: ratio = 8'd0;
         1: ratio = 8'd255;
         2: ratio = 8'($urandom_range(4, 20));
         default: ratio = 8'($urandom_range(1, 3));
      endcase
      case ($urandom_range(9))
         0: entries = 16'd0;
         1: entries = 16'd1;
         2: entries = 16'd65535;
         default: entries = 16'($urandom_range(2, 12));
      endcase
      case ($urandom_range(5))
         0: hz = 28'd0;
         1: hz = 28'hFFFFFFF;
         2: hz = 28'd200000000;
         default: hz = 28'($urandom_range(1, 100000000));
      endcase
      case ($urandom_range(5))
         0: tpu = 8'd0;
         1: tpu = 8'd255;
         default: tpu = 8'($urandom_range(1, 200));
      endcase
      write_all(ratio, entries, 16'($urandom_range(1, 65535)), 1'($urandom), hz, tpu);
      if ($urandom_range(3) == 0) push_ticks(1'b1, 1'($urandom), $urandom_range(1, 3));
      push_ticks(1'b0, 1'($urandom), 1);
      push_ticks(1'b1, 1'b0, $urandom_range(0, 3));
      bursts = $urandom_range(1, 3);
      repeat (bursts) begin
         repeat ($urandom_range(1, 3)) begin
            push_ticks(1'b1, 1'b1, $urandom_range(1, 3));
            push_ticks(1'b1, 1'b0, $urandom_range(1, 3));
         end
         push_ticks(1'b1, 1'b1, $urandom_range(1, 3));
         push_ticks(1'b1, 1'b0, $urandom_range(1, 40));
         if ($urandom_range(7) == 0)
            repeat ($urandom_range(4, 12)) push_ticks(1'b1, 1'($urandom), 1);
      end
      push_ticks(1'b1, 1'b1, 1);
      captures_run++;
   endtask

   initial begin
      reset = 1'b1;
      {psel, penable, pwrite} = 3'b000;
      paddr = '0;
      pwdata = '0;
      req_valid = 1'b0;
      rsp_ready = 1'b0;
      req_cmd = 1'b0;
      req_pin_level = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      m_ratio = SPACE_RATIO_RST;
      m_max_entries = MAX_ENTRIES_RST;
      m_max_units = MAX_TIME_UNITS_RST;
      m_wait = WAIT_FOR_HIGH_RST;
      m_tick_hz = TICK_HZ_RST;
      m_tpu = TICKS_PER_US_RST;
      m_phase = CAP_IDLE;
      {m_run, m_burst_high, m_burst_low, m_half_periods} = '0;
      {m_total_high, m_total_low, m_total_halves, m_spans, m_entries} = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // A short hand-built capture: ignored tick, waiting low, a joined low, one space,
      // then a second space that finds the list full.
      write_all(8'd1, 16'd3, 16'd129, 1'b1, 28'd84000000, 8'd1);
      push_ticks(1'b1, 1'b1, 1);
      push_ticks(1'b0, 1'b1, 1);
      push_ticks(1'b1, 1'b0, 1);
      push_ticks(1'b1, 1'b1, 2);
      push_ticks(1'b1, 1'b0, 1);
      push_ticks(1'b1, 1'b1, 1);
      push_ticks(1'b1, 1'b0, 5);
      push_ticks(1'b1, 1'b1, 1);
      push_ticks(1'b1, 1'b0, 3);
      push_ticks(1'b1, 1'b1, 1);
      drain();

      for (int i = 0; i < 9; i++) begin
         send_idle_pct = (i < 3) ? 16 : (i < 6) ? 87 : 0;
         recv_idle_pct = (i < 3) ? 87 : (i < 6) ? 16 : 0;
         random_capture();
         drain();
      end

      $display("covered one directed capture that fills its list and %0d random captures",
               captures_run);
      $display("%0d tick transfers accepted, %0d result transfers checked, %0d mismatches",
               ticks_accepted, entries_checked, errors);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
